@@ sv/gpio_serial_rtc_interface_core_assert.svh @@
// assertion macros used by the checker file
`ifndef GPIO_SERIAL_RTC_INTERFACE_CORE_ASSERT_SVH
`define GPIO_SERIAL_RTC_INTERFACE_CORE_ASSERT_SVH

// same-cycle implication
`define GSRI_ASSERT_NOW(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("gsri assertion failed");

// next-cycle implication
`define GSRI_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("gsri assertion failed");

`endif

@@ sv/gsri_pkg.sv @@
`timescale 1ns / 1ps
package gsri_pkg;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] ADDR_DATA   = 2'd0;
  localparam logic [1:0] ADDR_DIR    = 2'd1;
  localparam logic [1:0] ADDR_ENABLE = 2'd2;

  localparam logic [3:0] CMD_DIRECT_NIBBLE = 4'h6;

  localparam logic [2:0] REG_CONTROL  = 3'd1;
  localparam logic [2:0] REG_DATETIME = 3'd2;
  localparam logic [2:0] REG_TIME     = 3'd3;
  localparam logic [2:0] REG_IRQ      = 3'd6;

  localparam logic [2:0] LEN_CONTROL  = 3'd1;
  localparam logic [2:0] LEN_DATETIME = 3'd7;
  localparam logic [2:0] LEN_TIME     = 3'd3;

  localparam logic [2:0] LAST_BYTE = 3'd7;

  typedef struct packed {
    logic [2:0] pin_data;
    logic [3:0] pin_direction;
    logic       port_enable;
    logic       transfer_active;
    logic       reading;
    logic [7:0] command_shift;
    logic [2:0] command_bit_count;
    logic [2:0] register_length;
    logic [2:0] byte_index;
    logic [2:0] out_bit_index;
  } state_t;

  localparam state_t STATE_RESET = '{
    pin_data:          3'd0,
    pin_direction:     4'd0,
    port_enable:       1'b1,
    transfer_active:   1'b0,
    reading:           1'b0,
    command_shift:     8'd0,
    command_bit_count: 3'd0,
    register_length:   3'd0,
    byte_index:        3'd0,
    out_bit_index:     3'd0
  };

  typedef struct packed {
    logic       op;
    logic [1:0] addr;
    logic [3:0] wdata;
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [2:0] weekday_bcd;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
  } item_t;

  typedef struct packed {
    logic [3:0] rdata;
    logic       irq;
  } result_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = v[i];
    end
    return r;
  endfunction

endpackage

@@ sv/gsri_step.sv @@
`timescale 1ns / 1ps
module gsri_step (
  input  gsri_pkg::state_t  cur,
  input  gsri_pkg::item_t   item,
  input  logic [7:0]        rtc_control,
  output gsri_pkg::state_t  nxt,
  output gsri_pkg::result_t res
);
  import gsri_pkg::*;

  logic [2:0] prev;
  logic [2:0] dir_mask;
  logic [7:0] shifted;
  logic [7:0] cmd;
  logic [2:0] code;
  logic [7:0] date_byte;
  logic       sio;

  // field of the date/time stream selected by the byte counter
  always_comb begin
    unique case (cur.byte_index)
      3'd0:    date_byte = item.year_bcd;
      3'd1:    date_byte = {3'b000, item.month_bcd};
      3'd2:    date_byte = {2'b00, item.day_bcd};
      3'd3:    date_byte = {5'b00000, item.weekday_bcd};
      3'd4:    date_byte = {2'b00, item.hour_bcd};
      3'd5:    date_byte = {1'b0, item.minute_bcd};
      3'd6:    date_byte = {1'b0, item.second_bcd};
      default: date_byte = 8'd0;
    endcase
  end

  always_comb begin
    nxt      = cur;
    res      = '0;
    prev     = cur.pin_data;
    dir_mask = cur.pin_direction[2:0];
    shifted  = cur.command_shift;
    shifted[cur.command_bit_count] = 1'b0;
    cmd      = 8'd0;
    code     = 3'd0;
    sio      = 1'b0;

    if (item.op == OP_READ) begin
      if (cur.port_enable) begin
        unique case (item.addr)
          ADDR_DATA:   res.rdata = {1'b0, cur.pin_data & ~dir_mask};
          ADDR_DIR:    res.rdata = cur.pin_direction;
          ADDR_ENABLE: res.rdata = {3'b000, cur.port_enable};
          default:     res.rdata = 4'd0;
        endcase
      end
    end else begin
      unique case (item.addr)
        ADDR_DATA:   nxt.pin_data = (cur.pin_data & ~dir_mask) | (item.wdata[2:0] & dir_mask);
        ADDR_DIR:    nxt.pin_direction = item.wdata;
        ADDR_ENABLE: nxt.port_enable = item.wdata[0];
        default:     nxt.pin_data = cur.pin_data;
      endcase

      if (nxt.pin_data[0] && nxt.pin_data[2]) begin
        nxt.transfer_active = 1'b1;
      end

      if (nxt.transfer_active) begin
        // sck rising edge
        if (!prev[0] && nxt.pin_data[0]) begin
          if (cur.reading) begin
            if (cur.register_length == LEN_CONTROL) begin
              sio = rtc_control[cur.out_bit_index];
              nxt.pin_data[1] = sio;
            end else if (cur.register_length == LEN_DATETIME) begin
              sio = date_byte[cur.out_bit_index];
              nxt.pin_data[1] = sio;
            end
            nxt.out_bit_index = cur.out_bit_index + 3'd1;
            if (cur.out_bit_index == 3'd7 && cur.byte_index != LAST_BYTE) begin
              nxt.byte_index = cur.byte_index + 3'd1;
            end
          end else begin
            shifted[cur.command_bit_count] = nxt.pin_data[1];
            nxt.command_shift     = shifted;
            nxt.command_bit_count = cur.command_bit_count + 3'd1;
            if (cur.command_bit_count == 3'd7) begin
              // full command byte: decode it
              cmd  = (shifted[7:4] != CMD_DIRECT_NIBBLE) ? rev8(shifted) : shifted;
              code = cmd[3:1];
              nxt.command_shift = 8'd0;
              if (cmd[0]) begin
                nxt.reading    = 1'b1;
                nxt.byte_index = 3'd0;
              end
              if (code == REG_CONTROL) begin
                nxt.register_length = LEN_CONTROL;
              end else if (cmd[0] && code == REG_DATETIME) begin
                nxt.register_length = LEN_DATETIME;
              end else if (cmd[0] && code == REG_TIME) begin
                nxt.register_length = LEN_TIME;
              end else if (code == REG_IRQ) begin
                res.irq = 1'b1;
              end
            end
          end
        end
        // cs falling edge closes the transfer
        if (prev[2] && !nxt.pin_data[2]) begin
          nxt.transfer_active = 1'b0;
          nxt.reading         = 1'b0;
        end
      end
    end
  end

endmodule

@@ sv/gpio_serial_rtc_interface_core.sv @@
`timescale 1ns / 1ps
// channel  direction  handshake             payload
// in       to core    in_valid / in_stall   op addr wdata year..second_bcd
// out      from core  out_valid / out_stall rdata irq
// cfg      to core    cfg_write             cfg_data (rtc control value)
//
// one access per cycle while out_stall stays low; each access passes through the input
// register and then the result register before the result can transfer
// rst is synchronous: port enabled, pins, direction and command state cleared
// a stalled result holds; the input register still drains into the result
// register when that is free, so in_stall rises only with both stages full
module gpio_serial_rtc_interface_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [1:0] addr,
  input  logic [3:0] wdata,
  input  logic [7:0] year_bcd,
  input  logic [4:0] month_bcd,
  input  logic [5:0] day_bcd,
  input  logic [2:0] weekday_bcd,
  input  logic [5:0] hour_bcd,
  input  logic [6:0] minute_bcd,
  input  logic [6:0] second_bcd,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] rdata,
  output logic       irq
);
  import gsri_pkg::*;

  logic [7:0] rtc_control;
  state_t     state;
  state_t     state_next;
  item_t      stage;
  logic       stage_valid;
  result_t    res_next;
  logic       advance;
  logic       accept;

  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;
  assign accept   = in_valid && !in_stall;

  gsri_step u_step (
    .cur         (state),
    .item        (stage),
    .rtc_control (rtc_control),
    .nxt         (state_next),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rtc_control <= 8'd0;
    end else if (cfg_write) begin
      rtc_control <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= '{op: op, addr: addr, wdata: wdata, year_bcd: year_bcd,
                 month_bcd: month_bcd, day_bcd: day_bcd, weekday_bcd: weekday_bcd,
                 hour_bcd: hour_bcd, minute_bcd: minute_bcd, second_bcd: second_bcd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rdata <= res_next.rdata;
      irq   <= res_next.irq;
    end
  end

endmodule

@@ sv/gsri_checker.sv @@
`timescale 1ns / 1ps
`include "gpio_serial_rtc_interface_core_assert.svh"
module gsri_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] rdata,
  input logic       irq
);

  `GSRI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `GSRI_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(rdata) && $stable(irq))
  // irq only comes from a write, and writes return zero
  `GSRI_ASSERT_NOW(a_irq_on_write, clk, rst, out_valid && irq, rdata == 4'd0)
  // with the result register empty the input side never stalls
  `GSRI_ASSERT_NOW(a_no_stall_empty, clk, rst, !out_valid, !in_stall)

endmodule

bind gpio_serial_rtc_interface_core gsri_checker u_gsri_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .rdata     (rdata),
  .irq       (irq)
);
